### design/fnv1a_shard_router_core_macros.svh
// assertion helpers, clocked on clk, disabled while arst_n is low
`ifndef FNV1A_SHARD_ROUTER_CORE_MACROS_SVH
`define FNV1A_SHARD_ROUTER_CORE_MACROS_SVH

// same-cycle implication
`define FSR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/fsr_pkg.sv
`default_nettype none
package fsr_pkg;

	localparam int HASH_W = 64;
	localparam int STEP_W = 6;
	localparam logic [HASH_W-1:0] HASH_BASIS = 64'hcbf29ce484222325;

	typedef struct packed {
		logic accept;
		logic key_done;
		logic div_step;
		logic out_load;
	} fsr_cmd_t;

	typedef struct packed {
		logic count_zero;
	} fsr_status_t;

	// xor in the byte, then multiply by the prime 2^40 + 0x1b3
	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
		input logic [7:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage
`default_nettype wire

### design/fnv1a_shard_router_core.sv
// FNV-1a 64-bit key hasher with shard routing. Key bytes arrive one per beat on
// s_axis; tlast ends a key and tuser marks a beat with no byte (an empty key is
// one such beat with tlast). Beats inside a key are taken back to back. A
// key-ending beat starts a bit-serial remainder unit that yields one bit per
// cycle; the next beat is taken once the result is loaded into the output
// register. A zero shard_count skips the remainder and flags an error with
// index zero. The result waits there while bytes of the next key are taken.
// cfg writes set shard_count (reset 1) and must happen while the block is idle.
`default_nettype none
module fnv1a_shard_router_core #(
	parameter int SHARD_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire  [7:0]               s_axis_tdata,   // key_byte
	input  wire                      s_axis_tlast,   // key_end
	input  wire                      s_axis_tuser,   // no_byte
	output logic                     m_axis_tvalid,
	input  wire                      m_axis_tready,
	output logic [((SHARD_BITS+fsr_pkg::HASH_W+7)/8)*8-1:0] m_axis_tdata, // shard_index, key_hash
	output logic                     m_axis_tuser,   // count_error
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire  [SHARD_BITS-1:0]    cfg_data        // shard_count
);
	import fsr_pkg::*;

	fsr_cmd_t              cmd;
	fsr_status_t           status;
	logic [SHARD_BITS-1:0] shard_index;
	logic [HASH_W-1:0]     key_hash;

	assign cfg_ready = 1'b1;

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[SHARD_BITS-1:0] = shard_index;
		m_axis_tdata[SHARD_BITS+HASH_W-1:SHARD_BITS] = key_hash;
	end

	fsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	fsr_datapath #(
		.SHARD_BITS (SHARD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.key_byte    (s_axis_tdata),
		.no_byte     (s_axis_tuser),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.shard_index (shard_index),
		.key_hash    (key_hash),
		.count_error (m_axis_tuser)
	);

endmodule
`default_nettype wire

### design/fsr_datapath.sv
`default_nettype none
module fsr_datapath #(
	parameter int SHARD_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire fsr_pkg::fsr_cmd_t       cmd,
	output fsr_pkg::fsr_status_t         status,
	input  wire  [7:0]                   key_byte,
	input  wire                          no_byte,
	input  wire                          cfg_we,
	input  wire  [SHARD_BITS-1:0]        cfg_data,
	output logic [SHARD_BITS-1:0]        shard_index,
	output logic [fsr_pkg::HASH_W-1:0]   key_hash,
	output logic                         count_error
);
	import fsr_pkg::*;

	logic [HASH_W-1:0]     hash_q;
	logic [HASH_W-1:0]     key_hash_q;
	logic [HASH_W-1:0]     dividend_q;
	logic [SHARD_BITS-1:0] rem_q;
	logic [SHARD_BITS-1:0] count_q;
	logic [HASH_W-1:0]     next_hash;
	logic [SHARD_BITS:0]   rem_sh;
	logic [SHARD_BITS:0]   rem_sub;
	logic [SHARD_BITS-1:0] rem_next;

	assign next_hash = no_byte ? hash_q : fnv_step(hash_q, key_byte);
	assign status.count_zero = (count_q == '0);

	// one remainder bit per step
	assign rem_sh   = {rem_q, dividend_q[HASH_W-1]};
	assign rem_sub  = rem_sh - {1'b0, count_q};
	assign rem_next = (rem_sh >= {1'b0, count_q}) ? rem_sub[SHARD_BITS-1:0]
		: rem_sh[SHARD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= HASH_BASIS;
			count_q <= SHARD_BITS'(1);
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (cmd.key_done) begin
				hash_q <= HASH_BASIS;
			end else if (cmd.accept) begin
				hash_q <= next_hash;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.key_done) begin
			key_hash_q <= next_hash;
			dividend_q <= next_hash;
			rem_q      <= '0;
		end else if (cmd.div_step) begin
			dividend_q <= dividend_q << 1;
			rem_q      <= rem_next;
		end
		if (cmd.out_load) begin
			key_hash    <= key_hash_q;
			count_error <= status.count_zero;
			shard_index <= status.count_zero ? '0 : rem_q;
		end
	end

endmodule
`default_nettype wire

### design/fsr_ctrl.sv
`default_nettype none
module fsr_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	input  wire                     in_last,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire                     out_ready,
	input  wire fsr_pkg::fsr_status_t status,
	output fsr_pkg::fsr_cmd_t       cmd
);
	import fsr_pkg::*;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HASH_W - 1);

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	assign in_ready  = (state_q == ST_RUN);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.accept   = in_valid && in_ready;
		cmd.key_done = cmd.accept && in_last;
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_LOAD) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (cmd.key_done) begin
						step_q  <= '0;
						state_q <= status.count_zero ? ST_LOAD : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_LAST) begin
						state_q <= ST_LOAD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_LOAD: begin
					if (cmd.out_load) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### design/fsr_checker.sv
`default_nettype none
`include "fnv1a_shard_router_core_macros.svh"
module fsr_checker #(
	parameter int SHARD_BITS = 16
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   s_axis_tvalid,
	input wire                   s_axis_tready,
	input wire                   s_axis_tlast,
	input wire                   m_axis_tvalid,
	input wire                   m_axis_tready,
	input wire [((SHARD_BITS+64+7)/8)*8-1:0] m_axis_tdata,
	input wire                   m_axis_tuser
);

	// stalled result beat holds
	`FSR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"result changed while stalled")

	`FSR_ASSERT_IMPL(a_err_index, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata[SHARD_BITS-1:0] == '0, "error result with nonzero index")

	// key end drops tready (remainder pass, or straight to the load when shard_count is zero)
	`FSR_ASSERT_NEXT(a_busy_after_end, s_axis_tvalid && s_axis_tready && s_axis_tlast,
		!s_axis_tready, "input taken right after key end")

	`FSR_ASSERT_NEXT(a_ready_mid_key, s_axis_tvalid && s_axis_tready && !s_axis_tlast,
		s_axis_tready, "input stalled mid key")

endmodule

bind fnv1a_shard_router_core fsr_checker #(.SHARD_BITS(SHARD_BITS)) u_chk (.*);
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int SHARD_BITS = 16;
	localparam int OUT_W = ((SHARD_BITS + fsr_pkg::HASH_W + 7) / 8) * 8;
	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_ITEMS = 2000;

	typedef struct {
		logic [7:0] key_byte;
		logic       key_end;
		logic       no_byte;
	} key_beat_t;

	typedef struct {
		logic [SHARD_BITS-1:0] shard_index;
		logic [63:0]           key_hash;
		logic                  count_error;
	} route_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = 8'd0;  // key_byte
	logic                  s_axis_tlast = 1'b0;  // key_end
	logic                  s_axis_tuser = 1'b0;  // no_byte
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;         // shard_index, key_hash
	logic                  m_axis_tuser;         // count_error
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [SHARD_BITS-1:0] cfg_data = '0;

	key_beat_t             key_q[$];
	route_t                route_q[$];
	logic [63:0]           route_hash = FNV_BASIS;
	logic [SHARD_BITS-1:0] shard_cnt = SHARD_BITS'(1);

	bit  in_taken;
	bit  out_taken;
	bit  in_burst;
	bit  out_burst;
	int  in_wait;
	int  out_wait;
	int  errors;
	int  keys_checked;
	int  zero_count_keys;
	int  beats_in;
	int  settings_used;
	int  cycle_cnt;
	int  items_queued;

	fnv1a_shard_router_core #(
		.SHARD_BITS(SHARD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// fold one accepted beat into the running hash; a key end yields a route
	function automatic void hash_beat(input logic [7:0] b, input logic last, input logic nob);
		route_t r;
		if (!nob)
			route_hash = (route_hash ^ {56'd0, b}) * FNV_PRIME;
		if (last) begin
			r.key_hash = route_hash;
			r.count_error = (shard_cnt == 0);
			r.shard_index = r.count_error ? '0 :
				SHARD_BITS'(route_hash % {{(64-SHARD_BITS){1'b0}}, shard_cnt});
			route_q.push_back(r);
			route_hash = FNV_BASIS;
		end
	endfunction

	always @(posedge clk) begin
		in_taken = s_axis_tvalid && s_axis_tready;
		if (in_taken) begin
			beats_in++;
			hash_beat(s_axis_tdata, s_axis_tlast, s_axis_tuser);
		end
	end

	always @(negedge clk) begin
		key_beat_t nb;
		if (arst_n) begin
			if (s_axis_tvalid && !in_taken) begin
				// beat still waiting for tready
			end else if (in_wait > 0) begin
				s_axis_tvalid <= 1'b0;
				in_wait--;
			end else if (key_q.size() != 0) begin
				nb = key_q.pop_front();
				s_axis_tdata <= nb.key_byte;
				s_axis_tlast <= nb.key_end;
				s_axis_tuser <= nb.no_byte;
				s_axis_tvalid <= 1'b1;
				if ($urandom_range(0, 63) == 0)
					in_burst = !in_burst;
				in_wait = in_burst ? 0 : $urandom_range(0, 9);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				if ($urandom_range(0, 31) == 0)
					out_burst = !out_burst;
				out_wait = out_burst ? 0 : $urandom_range(0, 9);
			end
			if (out_wait > 0) begin
				m_axis_tready <= 1'b0;
				out_wait--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		route_t want;
		logic [SHARD_BITS-1:0] got_index;
		logic [63:0] got_hash;
		out_taken = m_axis_tvalid && m_axis_tready;
		if (out_taken) begin
			got_index = m_axis_tdata[SHARD_BITS-1:0];
			got_hash = m_axis_tdata[SHARD_BITS +: 64];
			if (route_q.size() == 0) begin
				$error("unexpected result beat: key_hash %h shard_index %0d", got_hash, got_index);
				errors++;
			end else begin
				want = route_q.pop_front();
				keys_checked++;
				if (want.count_error)
					zero_count_keys++;
				if (got_index !== want.shard_index) begin
					$error("shard_index mismatch: expected %0d, got %0d",
						want.shard_index, got_index);
					errors++;
				end
				if (got_hash !== want.key_hash) begin
					$error("key_hash mismatch: expected %h, got %h", want.key_hash, got_hash);
					errors++;
				end
				if (m_axis_tuser !== want.count_error) begin
					$error("count_error mismatch: expected %0b, got %0b",
						want.count_error, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	task automatic push_beat(input logic [7:0] b, input logic last, input logic nob);
		key_beat_t nb;
		nb.key_byte = b;
		nb.key_end = last;
		nb.no_byte = nob;
		key_q.push_back(nb);
		if (last || !nob)
			items_queued++;
	endtask

	// random key: bytes, sprinkled byteless beats, ended by the last byte or a byteless beat
	task automatic push_random_key();
		int len;
		bit byteless_end;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
		byteless_end = (len == 0) || ($urandom_range(0, 6) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0)
				push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			push_beat(8'($urandom_range(0, 255)), !byteless_end && (i == len - 1), 1'b0);
		end
		if (byteless_end)
			push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
	endtask

	task automatic wait_idle();
		while (key_q.size() != 0 || s_axis_tvalid || route_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_shard_count(input logic [SHARD_BITS-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		shard_cnt = v;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [SHARD_BITS-1:0] counts[$];
		int per_phase;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset count of one
		settings_used = 1;
		push_beat(8'hA5, 1'b1, 1'b1);
		push_beat(8'h00, 1'b1, 1'b0);
		push_beat(8'hFF, 1'b1, 1'b0);
		push_beat("a", 1'b0, 1'b0);
		push_beat(8'hFF, 1'b0, 1'b1);
		push_beat("b", 1'b0, 1'b0);
		push_beat("c", 1'b1, 1'b0);
		push_beat(8'h12, 1'b0, 1'b0);
		push_beat(8'h34, 1'b0, 1'b0);
		push_beat(8'hFF, 1'b1, 1'b1);
		wait_idle();

		set_shard_count('0);
		push_beat(8'h00, 1'b1, 1'b1);
		push_beat(8'h5A, 1'b0, 1'b0);
		push_beat(8'hC3, 1'b1, 1'b0);
		wait_idle();

		set_shard_count('1);
		push_beat(8'hFF, 1'b0, 1'b0);
		push_beat(8'hFF, 1'b1, 1'b0);
		push_beat(8'h00, 1'b1, 1'b1);
		push_beat(8'h80, 1'b1, 1'b0);
		wait_idle();

		counts = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'd100, 16'h8000,
			16'($urandom_range(1, 65535)), 16'($urandom_range(1, 255)),
			16'($urandom_range(256, 65535))};
		per_phase = RANDOM_ITEMS / counts.size();
		foreach (counts[p]) begin
			set_shard_count(counts[p]);
			items_queued = 0;
			while (items_queued < per_phase)
				push_random_key();
			wait_idle();
		end

		$display("Checked %0d routed keys from %0d input beats over %0d shard-count settings",
			keys_checked, beats_in, settings_used);
		$display("%0d keys took the zero-count error path", zero_count_keys);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/fsr_pkg.sv
design/fsr_datapath.sv
design/fsr_ctrl.sv
design/fnv1a_shard_router_core.sv
design/fsr_checker.sv
sim/testbench.sv
